/* rtl/assert_macros.svh */
// assertion macros for the legendre evaluation unit checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPE_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lpe assertion failed");

// next-cycle implication
`define LPE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lpe assertion failed");

`endif

/* rtl/lpe_pkg.sv */
// shared constants, types and the fixed point product for the legendre unit
// no dependencies
package lpe_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int MAX_TERMS  = 64;
  localparam int DERIV_BITS = 47;
  localparam int DIV_W      = 67;
  localparam int REM_W      = 31;
  localparam int STEP_W     = 7;

  localparam logic [STEP_W-1:0] P_STEPS  = 7'd38;
  localparam logic [STEP_W-1:0] D_STEPS  = 7'd67;
  localparam logic [6:0]        TC_RESET = 7'd16;
  localparam logic [6:0]        TC_MAX   = 7'(MAX_TERMS);

  localparam logic signed [31:0] ONE     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE = -32'sh4000_0000;

  typedef struct packed {
    logic done;
    logic round_up;
  } lpe_div_stat_t;

  // rounded q1.30 product, ties away from zero, operands within +-1.0
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] pr;
    logic [31:0] r;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    pr = ma * mb;
    r  = 32'((pr + 62'(1) * 62'h2000_0000) >> FRAC_BITS);
    return (a[31] != b[31]) ? -$signed(r) : $signed(r);
  endfunction

endpackage

/* rtl/lpe_if.sv */
// handshake channels of the legendre unit: argument, result and configuration
// no dependencies
interface lpe_x_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface lpe_res_if;
  logic               valid;
  logic               ready;
  logic [5:0]         degree;
  logic signed [31:0] poly_value;
  logic signed [46:0] deriv_value;
  logic               last;
  modport source (output valid, output degree, output poly_value, output deriv_value,
                  output last, input ready);
  modport sink   (input valid, input degree, input poly_value, input deriv_value,
                  input last, output ready);
endinterface

interface lpe_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] term_count;
  modport source (output valid, output term_count, input ready);
  modport sink   (input valid, input term_count, output ready);
endinterface

/* rtl/lpe_div.sv */
// restoring divider, one quotient bit per cycle, shared by both quotients
// depends on lpe_pkg
module lpe_div import lpe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [REM_W-1:0]    divisor,
  input  logic [STEP_W-1:0]   steps,
  output logic [DIV_W-1:0]    quot,
  output lpe_div_stat_t       stat
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsr;
  logic [REM_W:0]    cand;
  logic              ge;
  logic [REM_W-1:0]  rem_next;

  assign cand     = {rem, quot[DIV_W-1]};
  assign ge       = cand >= {1'b0, dsr};
  assign rem_next = ge ? REM_W'(cand - {1'b0, dsr}) : cand[REM_W-1:0];

  assign stat.done     = done;
  assign stat.round_up = {rem, 1'b0} >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quot <= dividend;
        dsr  <= divisor;
        cnt  <= steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= rem_next;
        quot <= {quot[DIV_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/legendre_poly_eval_unit.sv */
// legendre polynomial and derivative evaluation, top level and sequencer
// depends on lpe_pkg, lpe_if and lpe_div
// One argument x (Q1.30, clamped to +-1.0) yields term_count results, degree 0 upward
// (a term_count of 0 gives one result, above 64 gives 64), each with P_n(x) in Q1.30
// and dP_n/dx in saturating Q16.30, last set on the final degree. The argument port
// is not ready from acceptance until the last result is taken. After acceptance,
// S_DEN sets up 1-x^2. A degree with a derivative quotient then passes through the
// shared 31x31 multiplier, forms both numerators, starts the shared bit-serial
// divider, waits on its 38 steps for the recurrence quotient, restarts it, waits on
// its 67 steps for the derivative quotient, and holds the result for the output
// handshake until the receiver takes it. Degree 0 and the end points x = +-1 skip
// the derivative quotient.
module legendre_poly_eval_unit import lpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lpe_cfg_if.sink    cfg,
  lpe_x_if.sink      arg,
  lpe_res_if.source  res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEN, S_MUL, S_PREP, S_PST, S_PDIV, S_DST, S_DDIV, S_OUT
  } state_t;

  state_t             state;
  logic [6:0]         term_count;
  logic [6:0]         count;
  logic signed [31:0] x;
  logic               at_end;
  logic [REM_W-1:0]   den;
  logic [5:0]         n;
  logic signed [31:0] p_prev;
  logic signed [31:0] p_cur;
  logic signed [31:0] p_next;
  logic signed [31:0] t;
  logic signed [39:0] pnum;
  logic signed [39:0] dnum;
  logic signed [46:0] deriv;

  logic signed [31:0] x_clamped;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_res;
  logic signed [32:0] dd;
  logic signed [39:0] k1;
  logic signed [39:0] k0;
  logic signed [39:0] pnum_c;
  logic signed [39:0] dnum_c;
  logic [6:0]         np1;
  logic [39:0]        pmag;
  logic [39:0]        dmag;
  logic [DIV_W-1:0]   div_dvd;
  logic [REM_W-1:0]   div_dsr;
  logic [STEP_W-1:0]  div_steps;
  logic               div_start;
  logic [DIV_W-1:0]   quot;
  lpe_div_stat_t      div_stat;
  logic [30:0]        pq;
  logic signed [31:0] p_res;
  logic [67:0]        qr;
  logic [46:0]        dq;
  logic signed [46:0] d_res;
  logic [12:0]        nn1;
  logic signed [46:0] edge_val;
  logic               is_last;

  assign x_clamped = (arg.x_value > ONE) ? ONE :
                     (arg.x_value < NEG_ONE) ? NEG_ONE : arg.x_value;

  assign mul_b   = (state == S_DEN) ? x : p_cur;
  assign mul_res = mulq(x, mul_b);
  assign dd      = 33'(ONE) - 33'(mul_res);

  assign np1    = {1'b0, n} + 7'd1;
  assign k1     = 40'($signed({1'b0, n, 1'b1}));
  assign k0     = 40'($signed({1'b0, n}));
  assign pnum_c = k1 * 40'(t) - k0 * 40'(p_prev);
  assign dnum_c = k0 * (40'(p_prev) - 40'(t));

  assign pmag = pnum[39] ? 40'(-pnum) : 40'(pnum);
  assign dmag = dnum[39] ? 40'(-dnum) : 40'(dnum);

  // recurrence quotient is rounded by adding half the divisor up front
  always_comb begin
    if (state == S_DST) begin
      div_dvd   = {dmag[36:0], 30'b0};
      div_dsr   = den;
      div_steps = D_STEPS;
    end else begin
      div_dvd   = {38'(pmag[37:0] + 38'(np1[6:1])), 29'b0};
      div_dsr   = REM_W'(np1);
      div_steps = P_STEPS;
    end
  end
  assign div_start = (state == S_PST) || (state == S_DST);

  lpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .quot     (quot),
    .stat     (div_stat)
  );

  assign pq    = (quot > DIV_W'(ONE)) ? 31'(ONE) : quot[30:0];
  assign p_res = pnum[39] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});

  // derivative saturates to the 47 bit signed range
  always_comb begin
    qr = 68'(quot) + 68'(div_stat.round_up);
    if (dnum[39]) begin
      dq    = (qr > 68'(1) << 46) ? 47'h4000_0000_0000 : qr[46:0];
      d_res = $signed(47'(0) - dq);
    end else begin
      dq    = (qr > (68'(1) << 46) - 68'd1) ? 47'h3FFF_FFFF_FFFF : qr[46:0];
      d_res = $signed(dq);
    end
  end

  assign nn1      = 13'(n) * 13'(np1);
  assign edge_val = (x[31] && !n[0]) ? -$signed({5'b0, nn1[12:1], 30'b0})
                                     : $signed({5'b0, nn1[12:1], 30'b0});

  assign is_last = (np1 == count);

  assign cfg.ready       = 1'b1;
  assign arg.ready       = (state == S_IDLE);
  assign res.valid       = (state == S_OUT);
  assign res.degree      = n;
  assign res.poly_value  = p_cur;
  assign res.deriv_value = deriv;
  assign res.last        = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      term_count <= TC_RESET;
    end else begin
      if (cfg.valid) begin
        term_count <= cfg.term_count;
      end
      case (state)
        S_IDLE: begin
          if (arg.valid) begin
            x      <= x_clamped;
            at_end <= (x_clamped == ONE) || (x_clamped == NEG_ONE);
            count  <= (term_count == 7'd0) ? 7'd1 :
                      (term_count > TC_MAX) ? TC_MAX : term_count;
            state  <= S_DEN;
          end
        end
        S_DEN: begin
          den    <= (dd < 33'sd1) ? REM_W'(1) : dd[REM_W-1:0];
          n      <= '0;
          p_prev <= '0;
          p_cur  <= ONE;
          state  <= S_MUL;
        end
        S_MUL: begin
          t     <= mul_res;
          state <= S_PREP;
        end
        S_PREP: begin
          pnum  <= pnum_c;
          dnum  <= dnum_c;
          state <= S_PST;
        end
        S_PST: begin
          state <= S_PDIV;
        end
        S_PDIV: begin
          if (div_stat.done) begin
            p_next <= p_res;
            if (n == 6'd0) begin
              deriv <= '0;
              state <= S_OUT;
            end else if (at_end) begin
              deriv <= edge_val;
              state <= S_OUT;
            end else begin
              state <= S_DST;
            end
          end
        end
        S_DST: begin
          state <= S_DDIV;
        end
        S_DDIV: begin
          if (div_stat.done) begin
            deriv <= d_res;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res.ready) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              n      <= n + 6'd1;
              p_prev <= p_cur;
              p_cur  <= p_next;
              state  <= S_MUL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lpe_checker.sv */
// port-level checks of the legendre unit, attached to the top level by bind
// depends on lpe_if and assert_macros.svh
`include "assert_macros.svh"

module lpe_checker (
  input logic       clk,
  input logic       rst,
  lpe_x_if.sink     arg,
  lpe_res_if.source res
);

  `LPE_ASSERT_NEXT(a_res_hold, clk, rst, res.valid && !res.ready, res.valid)
  `LPE_ASSERT_NEXT(a_busy_after_arg, clk, rst, arg.valid && arg.ready, !arg.ready && !res.valid)
  `LPE_ASSERT_IMPL(a_no_overlap, clk, rst, res.valid, !arg.ready)
  `LPE_ASSERT_NEXT(a_run_goes_on, clk, rst, res.valid && res.ready && !res.last, !arg.ready)

endmodule

bind legendre_poly_eval_unit lpe_checker u_lpe_checker (
  .clk (clk),
  .rst (rst),
  .arg (arg),
  .res (res)
);
